[design/fdcd_pkg.sv]
// ----------------------------------------------------------------------------
// fdcd_pkg: shared types and constants for the frame difference cut detector
// Register indexes, field widths, reset values and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package fdcd_pkg;

    // Field widths
    localparam int CHAN_W   = 8;
    localparam int FIDX_W   = 24;
    localparam int THR_W    = 10;
    localparam int PCNT_W   = 23;
    localparam int FMS_W    = 27;
    localparam int ID_W     = 24;
    localparam int MS_W     = 32;
    localparam int SCORE_W  = 10;
    localparam int SUM_W    = 32;
    localparam int PX_W     = 10;
    localparam int PROD_W   = FIDX_W + FMS_W;
    localparam int FRAC_W   = 16;
    localparam int REM_W    = 22;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    // Limits
    localparam logic [PCNT_W-1:0]  MAX_PIXELS = PCNT_W'(4194304);
    localparam logic [SCORE_W-1:0] SCORE_MAX  = SCORE_W'(765);
    localparam logic [ID_W-1:0]    ID_MAX     = '1;

    // Division steps (one quotient bit per cycle)
    localparam int DIV_STEPS = SUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Register reset values
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(60);
    localparam logic [PCNT_W-1:0] PCNT_RESET = PCNT_W'(307200);
    localparam logic [FMS_W-1:0]  FMS_RESET  = FMS_W'(2621440);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CUT_THRESHOLD = 2'd0,
        REG_PIXEL_COUNT   = 2'd1,
        REG_FRAME_MS_Q16  = 2'd2
    } cfg_reg_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DIV,
        ST_SCORE,
        ST_EVAL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic div_step;
        logic score_load;
        logic eval_en;
        logic emit_en;
    } cmd_t;

    typedef struct packed {
        logic last_accept;
        logic cut;
        logic out_free;
    } status_t;

endpackage

[design/fdcd_ctrl.sv]
// ----------------------------------------------------------------------------
// fdcd_ctrl: sequencing controller
// Steps through pixel accumulation, the bit-serial divide, scoring, the cut
// decision and the hand-off of a cut record to the output register.
// ----------------------------------------------------------------------------
module fdcd_ctrl
    import fdcd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output cmd_t    cmd
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // State and divide step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_ACCUM:
            begin
                cnt_next = '0;
                if (status.last_accept)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_SCORE;
            end
            ST_SCORE:
                state_next = ST_EVAL;
            ST_EVAL:
                state_next = status.cut ? ST_EMIT : ST_ACCUM;
            ST_EMIT:
            begin
                if (status.out_free)
                    state_next = ST_ACCUM;
            end
            default:
                state_next = ST_ACCUM;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_ACCUM: cmd.in_ready   = 1'b1;
            ST_DIV:   cmd.div_step   = 1'b1;
            ST_SCORE: cmd.score_load = 1'b1;
            ST_EVAL:  cmd.eval_en    = 1'b1;
            ST_EMIT:  cmd.emit_en    = status.out_free;
            default:  cmd = '0;
        endcase
    end

    // A frame end always starts a fresh divide
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCUM && status.last_accept) |=>
            (state_reg == ST_DIV && cnt_reg == '0))
        else $error("divide did not start cleanly after frame end");

    // The divide runs its full step count before scoring
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCORE) |-> ($past(state_reg) == ST_DIV &&
            $past(cnt_reg) == CNT_W'(DIV_STEPS - 1)))
        else $error("scoring entered before divide finished");

    // No record is produced for a frame without a cut
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && !status.cut) |=> (state_reg == ST_ACCUM))
        else $error("non-cut frame did not return to accumulation");

    // A pending record is handed over as soon as the output slot frees
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && status.out_free) |-> cmd.emit_en)
        else $error("record not loaded into free output slot");

endmodule

[design/fdcd_dp.sv]
// ----------------------------------------------------------------------------
// fdcd_dp: datapath
// Configuration registers, saturating difference accumulator, restoring
// divider, score and cut logic, start time multiply and output register.
// ----------------------------------------------------------------------------
module fdcd_dp
    import fdcd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    logic [THR_W-1:0]   thr_reg;
    logic [PCNT_W-1:0]  pcnt_reg;
    logic [FMS_W-1:0]   fms_reg;

    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SUM_W-1:0]   quo_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [PCNT_W-1:0]  divisor_reg;
    logic [FIDX_W-1:0]  fidx_reg;
    logic [SCORE_W-1:0] score_reg, last_score_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [ID_W-1:0]    shot_cnt_reg;

    logic               out_valid_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [MS_W-1:0]    out_ms_reg;
    logic [SCORE_W-1:0] out_score_reg;

    logic               in_accept;
    logic [CHAN_W-1:0]  d_red, d_green, d_blue;
    logic [PX_W-1:0]    px;
    logic [SUM_W:0]     sum_ext;
    logic [PCNT_W-1:0]  divisor;
    logic [REM_W:0]     trial;
    logic               trial_ge;
    logic [SCORE_W-1:0] score_sat;
    logic [SCORE_W-1:0] change;
    logic [MS_W-1:0]    ms_sat;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            pcnt_reg <= PCNT_RESET;
            fms_reg  <= FMS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CUT_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                REG_PIXEL_COUNT:   pcnt_reg <= cfg_data[PCNT_W-1:0];
                REG_FRAME_MS_Q16:  fms_reg  <= cfg_data[FMS_W-1:0];
                default:           ;
            endcase
        end
    end

    // Per-pixel absolute channel differences
    function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
        absdiff = (a > b) ? a - b : b - a;
    endfunction

    assign in_accept = s_tvalid && cmd.in_ready;
    assign d_red     = absdiff(s_tdata[7:0],   s_tdata[31:24]);
    assign d_green   = absdiff(s_tdata[15:8],  s_tdata[39:32]);
    assign d_blue    = absdiff(s_tdata[23:16], s_tdata[47:40]);
    assign px        = PX_W'(d_red) + PX_W'(d_green) + PX_W'(d_blue);

    // Saturating accumulate, including the last pixel of the frame
    assign sum_ext  = {1'b0, sum_reg} + (SUM_W+1)'(px);
    assign sum_next = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

    // Clamp the divisor into one to the frame size limit
    always_comb
    begin
        if (pcnt_reg == '0)
            divisor = PCNT_W'(1);
        else if (pcnt_reg > MAX_PIXELS)
            divisor = MAX_PIXELS;
        else
            divisor = pcnt_reg;
    end

    // Restoring divide step: one quotient bit per cycle
    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_ge = trial >= divisor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (in_accept)
            sum_reg <= s_tlast ? '0 : sum_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && s_tlast)
        begin
            quo_reg     <= sum_next;
            rem_reg     <= '0;
            divisor_reg <= divisor;
            fidx_reg    <= s_tdata[71:48];
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], trial_ge};
            rem_reg <= trial_ge ? REM_W'(trial - divisor_reg) : trial[REM_W-1:0];
        end
    end

    // Score with saturation, and the start time product
    assign score_sat = (quo_reg > SUM_W'(SCORE_MAX)) ? SCORE_MAX : quo_reg[SCORE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.score_load)
        begin
            score_reg <= score_sat;
            prod_reg  <= PROD_W'(fidx_reg) * PROD_W'(fms_reg);
        end
    end

    // Cut decision against the previous frame's score
    assign change     = (score_reg > last_score_reg) ? score_reg - last_score_reg
                                                     : last_score_reg - score_reg;
    assign status.cut = (change > thr_reg) && (score_reg > thr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_score_reg <= '0;
            shot_cnt_reg   <= '0;
        end
        else if (cmd.eval_en)
        begin
            last_score_reg <= score_reg;
            if (status.cut && shot_cnt_reg != ID_MAX)
                shot_cnt_reg <= shot_cnt_reg + 1'b1;
        end
    end

    // Drop the fraction and saturate the start time
    assign ms_sat = (prod_reg[PROD_W-1:FRAC_W+MS_W] != '0) ? '1
                                                           : prod_reg[FRAC_W+MS_W-1:FRAC_W];

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_en)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_en)
        begin
            out_id_reg    <= shot_cnt_reg;
            out_ms_reg    <= ms_sat;
            out_score_reg <= score_reg;
        end
    end

    assign status.last_accept = in_accept && s_tlast;
    assign status.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W-ID_W-MS_W-SCORE_W)'(0), out_score_reg, out_ms_reg,
                       out_id_reg};

    // The running sum restarts after every frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        status.last_accept |=> (sum_reg == '0))
        else $error("frame sum not cleared after last pixel");

    // A held record is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> ($stable(out_id_reg) && $stable(out_ms_reg)
            && $stable(out_score_reg)))
        else $error("pending record changed under stall");

endmodule

[design/frame_difference_cut_detector_core.sv]
// ----------------------------------------------------------------------------
// frame_difference_cut_detector_core: shot boundary detector
// Scores each frame by its mean absolute RGB difference to the previous one
// and emits a cut record when score and score change exceed a threshold.
//
//   Channel  Handshake          Payload
//   s_*      s_tvalid/s_tready  tdata: cur_red, cur_green, cur_blue, old_red,
//                               old_green, old_blue, frame_index; tlast: last_pixel
//   m_*      m_tvalid/m_tready  tdata: shot_id, start_ms, shot_score
//   cfg_*    cfg_we             cfg_index 0..2, cfg_data
//
// Pixels are taken one per cycle while s_tready is high. The last pixel of a
// frame starts the restoring divide, then score/multiply and the cut decision
// follow; a cut frame adds the record hand-off. s_tready is low from the
// frame end until that sequence finishes; a record still waiting in the
// output register holds the next cut frame in its hand-off, with s_tready low.
// Reset restores register defaults and clears sum, last score and shot count.
// ----------------------------------------------------------------------------
module frame_difference_cut_detector_core
    import fdcd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [7:0] cur_red, [15:8] cur_green, [23:16] cur_blue, [31:24] old_red,
    // [39:32] old_green, [47:40] old_blue, [71:48] frame_index
    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [23:0] shot_id, [55:24] start_ms, [65:56] shot_score, [71:66] zero
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    cmd_t    cmd;
    status_t status;

    fdcd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    fdcd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    assign s_tready = cmd.in_ready;

endmodule
